// File: rtl/mkc_pkg.sv
package mkc_pkg;

  localparam int unsigned Entries   = 16;
  localparam int unsigned KeyWidth  = 32;
  localparam int unsigned CountW    = 32;
  localparam int unsigned DistW     = 5;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } mkc_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } mkc_state_e;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] key;
  } mkc_in_t;

  typedef struct packed {
    logic [31:0] key_count;
    logic [4:0]  distinct_keys;
    logic        table_full_drop;
  } mkc_out_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic                exec;
    logic                insert;
    mkc_op_e             op;
    logic [KeyWidth-1:0] key;
  } mkc_cmd_t;

  function automatic logic [KeyWidth-1:0] form_key(input logic signed [31:0] raw);
    logic signed [63:0] ext;
    ext = 64'(raw);
    return ext[KeyWidth-1:0];
  endfunction

  function automatic mkc_op_e decode_op(input logic [1:0] func);
    mkc_op_e op;
    case (func)
      OP_ADD:    op = OP_ADD;
      OP_REMOVE: op = OP_REMOVE;
      default:   op = OP_QUERY;
    endcase
    return op;
  endfunction

endpackage

// File: rtl/mkc_cell.sv
module mkc_cell import mkc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mkc_cmd_t          cmd_i,
  input  logic              free_found_i,
  input  logic [CountW-1:0] count_i,
  output logic              free_found_o,
  output logic [CountW-1:0] count_o,
  output logic              match_o,
  output logic              take_o,
  output logic              freed_o
);

  logic                valid_q, valid_d;
  logic [KeyWidth-1:0] key_q;
  logic [CountW-1:0]   count_q;
  logic [CountW-1:0]   new_count;

  assign match_o      = valid_q && (key_q == cmd_i.key);
  // lowest free entry claims the insert, higher ones see it as taken
  assign take_o       = cmd_i.insert && !valid_q && !free_found_i;
  assign free_found_o = free_found_i || !valid_q;

  always_comb begin
    case (cmd_i.op)
      OP_ADD:    new_count = (count_q == CountMax) ? count_q : count_q + CountW'(1);
      OP_REMOVE: new_count = count_q - CountW'(1);
      default:   new_count = count_q;
    endcase
  end

  assign freed_o = match_o && (cmd_i.op == OP_REMOVE) && (count_q == CountW'(1));

  always_comb begin
    count_o = count_i;
    if (match_o) begin
      count_o = count_i | new_count;
    end else if (take_o) begin
      count_o = count_i | CountW'(1);
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.exec) begin
      if (take_o) begin
        valid_d = 1'b1;
      end else if (freed_o) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (take_o) begin
        key_q   <= cmd_i.key;
        count_q <= CountW'(1);
      end else if (match_o) begin
        count_q <= new_count;
      end
    end
  end

endmodule

// File: rtl/multiset_key_counter.sv
// multiset key counter: a row of Entries cells, each holding one key and its count
//
// input side: present in_i with start high; the word is taken at a clock edge where
// start is high and busy is low. func selects add, remove or query; func 3 is a query.
// output side: out_valid_o is high for exactly one cycle with out_o holding the key's
// count after the operation, the number of distinct keys held and the full-drop flag.
// there is no backpressure; the receiver must take every result word as it appears.
//
// timing: a word taken at a clock edge is executed in the following cycle (busy high)
// and its result is on out_o in the cycle after that. no new word is taken while busy
// is high. the execute cycle is set by the key compare in every cell, the free-slot
// chain running from cell 0 upward and the count chain collecting the matching
// cell's count; all cells write back at the end of that same cycle, so the next
// word always sees the updated table.
//
// reset clears every valid bit and the distinct-key counter; the table starts empty
// and a word can be taken in the first cycle after reset is released.
module multiset_key_counter import mkc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  mkc_in_t  in_i,
  output logic     out_valid_o,
  output mkc_out_t out_o
);

  mkc_state_e state_q, state_d;
  mkc_op_e    op_q;
  logic [KeyWidth-1:0] key_q;
  logic [DistW-1:0]    distinct_q, distinct_d;
  logic       out_valid_q, out_valid_d;
  mkc_out_t   out_q;

  logic       accept;
  mkc_cmd_t   cmd;
  logic [Entries:0] free_chain;
  logic [CountW-1:0] count_chain [Entries+1];
  logic [Entries-1:0] match_vec, take_vec, freed_vec;
  logic       hit_any, freed_any, inserted, dropped;

  assign busy   = (state_q == ST_EXEC);
  assign accept = start && !busy;

  always_comb begin
    state_d     = state_q;
    out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      distinct_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      distinct_q  <= distinct_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= decode_op(in_i.func);
      key_q <= form_key(in_i.key);
    end
    if (busy) begin
      out_q.key_count       <= count_chain[Entries];
      out_q.distinct_keys   <= distinct_d;
      out_q.table_full_drop <= dropped;
    end
  end

  assign hit_any   = |match_vec;
  assign freed_any = |freed_vec;

  assign cmd.exec   = busy;
  assign cmd.op     = op_q;
  assign cmd.key    = key_q;
  assign cmd.insert = (op_q == OP_ADD) && !hit_any;

  assign free_chain[0]  = 1'b0;
  assign count_chain[0] = '0;

  for (genvar i = 0; i < Entries; i++) begin : g_cell
    mkc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .free_found_i (free_chain[i]),
      .count_i      (count_chain[i]),
      .free_found_o (free_chain[i+1]),
      .count_o      (count_chain[i+1]),
      .match_o      (match_vec[i]),
      .take_o       (take_vec[i]),
      .freed_o      (freed_vec[i])
    );
  end

  assign inserted = cmd.insert && free_chain[Entries];
  assign dropped  = cmd.insert && !free_chain[Entries];

  always_comb begin
    distinct_d = distinct_q;
    if (busy) begin
      if (inserted) begin
        distinct_d = distinct_q + DistW'(1);
      end else if (freed_any) begin
        distinct_d = distinct_q - DistW'(1);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_one_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> $onehot0(match_vec))
    else $error("key held in more than one entry");

  a_one_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> ($onehot0(take_vec) && ((|take_vec) == inserted)))
    else $error("insert claimed by wrong number of entries");

  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (out_valid_o && !busy))
    else $error("result strobe missing after execute cycle");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.table_full_drop) |-> (out_o.key_count == '0))
    else $error("dropped add reports nonzero count");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted word not executed");

endmodule
